// ===== hw/rtl/trd_pkg.sv =====
// Shared types and constants for the triangle raster / depth test block.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package trd_pkg;

	// Fixed point formats of the vertex fields and the barycentric weights
	localparam int COORD_FRAC_BITS = 4;
	localparam int WEIGHT_BITS     = 24;
	localparam int QW              = WEIGHT_BITS + 1;  // weight including the integer bit

	// Edge function accumulators and divider operands
	localparam int EW  = 40;
	localparam int DVW = 36;

	// Pixel store word: depth in the upper bits, colour below
	localparam int COLOUR_W = 64;
	localparam int DEPTH_W  = 32;
	localparam int STORE_W  = COLOUR_W + DEPTH_W;

	localparam int DEF_MAX_WIDTH  = 128;
	localparam int DEF_MAX_HEIGHT = 128;

	localparam logic [7:0]  SIZE_RESET = 8'd128;
	localparam logic [31:0] DEPTH_BIAS = 32'h8000_0000;

	typedef enum logic [1:0] {
		CMD_VERTEX = 2'd0,
		CMD_READ   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ACTIVE_WIDTH  = 2'd0,
		REG_ACTIVE_HEIGHT = 2'd1
	} reg_idx_t;

endpackage

// ===== hw/rtl/trd_store.sv =====
// Single-port pixel store: colour and depth per pixel, registered read data.
// Depends on trd_pkg for the word width.
`timescale 1ns / 1ps

module trd_store #(
	parameter int DEPTH = trd_pkg::DEF_MAX_WIDTH * trd_pkg::DEF_MAX_HEIGHT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic                        we,
	input  logic [AW-1:0]               addr,
	input  logic [trd_pkg::STORE_W-1:0] wdata,
	output logic [trd_pkg::STORE_W-1:0] rdata
);
	import trd_pkg::*;

	logic [STORE_W-1:0] mem [DEPTH];

	// write or read one word per cycle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== hw/rtl/trd_divider.sv =====
// Two-lane restoring divider producing the s and t barycentric weights.
// One quotient bit per cycle; depends on trd_pkg for widths.
`timescale 1ns / 1ps

module trd_divider (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [trd_pkg::DVW-1:0] num_a,
	input  logic [trd_pkg::DVW-1:0] num_b,
	input  logic [trd_pkg::DVW-1:0] den,
	output logic                    done,
	output logic [trd_pkg::QW-1:0]  quo_a,
	output logic [trd_pkg::QW-1:0]  quo_b
);
	import trd_pkg::*;

	localparam int CW = $clog2(WEIGHT_BITS + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DVW-1:0] rem_a_q, rem_b_q, den_q;
	logic [QW-1:0]  quo_a_q, quo_b_q;
	logic [DVW:0]   ra2, rb2, ra_sub, rb_sub;
	logic           ge_a, ge_b, int_a, int_b;

	// one shift and trial subtract per lane
	always_comb begin
		ra2    = {rem_a_q, 1'b0};
		rb2    = {rem_b_q, 1'b0};
		ra_sub = ra2 - {1'b0, den_q};
		rb_sub = rb2 - {1'b0, den_q};
		ge_a   = ra2 >= {1'b0, den_q};
		ge_b   = rb2 >= {1'b0, den_q};
		int_a  = num_a >= den;
		int_b  = num_b >= den;
	end

	// sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WEIGHT_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// hold remainders and shift in quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			den_q   <= den;
			rem_a_q <= int_a ? num_a - den : num_a;
			rem_b_q <= int_b ? num_b - den : num_b;
			quo_a_q <= QW'(int_a);
			quo_b_q <= QW'(int_b);
		end else if (busy_q) begin
			rem_a_q <= ge_a ? ra_sub[DVW-1:0] : ra2[DVW-1:0];
			rem_b_q <= ge_b ? rb_sub[DVW-1:0] : rb2[DVW-1:0];
			quo_a_q <= {quo_a_q[QW-2:0], ge_a};
			quo_b_q <= {quo_b_q[QW-2:0], ge_b};
		end
	end

	assign done  = done_q;
	assign quo_a = quo_a_q;
	assign quo_b = quo_b_q;

endmodule

// ===== hw/rtl/trd_blend.sv =====
// Shared multiply-accumulate unit that interpolates depth and four colour
// channels from the three barycentric weights. Depends on trd_pkg.
`timescale 1ns / 1ps

module trd_blend (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [trd_pkg::QW-1:0]       ws,
	input  logic [trd_pkg::QW-1:0]       wt,
	input  logic [31:0]                  vdepth [3],
	input  logic [trd_pkg::COLOUR_W-1:0] vcolour [3],
	output logic                         done,
	output logic [31:0]                  depth_sum,
	output logic [trd_pkg::COLOUR_W-1:0] colour
);
	import trd_pkg::*;

	localparam int NCH = 5;
	localparam int PW  = QW + 32;
	localparam logic [2:0] LAST_CH = 3'(NCH - 1);

	logic          busy_q;
	logic [2:0]    ch_q;
	logic [1:0]    wsel_q;
	logic          v_s1, last_s1, done_q;
	logic [2:0]    ch_s1;
	logic [PW-1:0] prod_s1, acc_q, sum;
	logic [QW-1:0] ws_q, wt_q, wu_q, weight;
	logic [1:0]    vi;
	logic [31:0]   operand;
	logic [PW-1:0] prod;
	logic [31:0]   res_q [NCH];

	// pick weight and vertex operand for this step
	always_comb begin
		case (wsel_q)
			2'd0:    begin weight = ws_q; vi = 2'd1; end
			2'd1:    begin weight = wt_q; vi = 2'd2; end
			default: begin weight = wu_q; vi = 2'd0; end
		endcase
		case (ch_q)
			3'd0:    operand = vdepth[vi] ^ DEPTH_BIAS;
			3'd1:    operand = 32'(vcolour[vi][15:0]);
			3'd2:    operand = 32'(vcolour[vi][31:16]);
			3'd3:    operand = 32'(vcolour[vi][47:32]);
			default: operand = 32'(vcolour[vi][63:48]);
		endcase
		prod = PW'(weight) * PW'(operand);
		sum  = acc_q + prod_s1;
	end

	// step through channels and weights
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ch_q   <= '0;
			wsel_q <= '0;
			v_s1   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= busy_q;
			done_q <= v_s1 && last_s1 && (ch_s1 == LAST_CH);
			if (start) begin
				busy_q <= 1'b1;
				ch_q   <= '0;
				wsel_q <= '0;
			end else if (busy_q) begin
				if (wsel_q == 2'd2) begin
					wsel_q <= '0;
					ch_q   <= ch_q + 3'd1;
					if (ch_q == LAST_CH) begin
						busy_q <= 1'b0;
					end
				end else begin
					wsel_q <= wsel_q + 2'd1;
				end
			end
		end
	end

	// register products, then accumulate per channel
	always_ff @(posedge clk) begin
		if (start) begin
			ws_q  <= ws;
			wt_q  <= wt;
			wu_q  <= {1'b1, {WEIGHT_BITS{1'b0}}} - ws - wt;
			acc_q <= '0;
		end
		prod_s1 <= prod;
		last_s1 <= wsel_q == 2'd2;
		ch_s1   <= ch_q;
		if (v_s1) begin
			if (last_s1) begin
				res_q[ch_s1] <= sum[WEIGHT_BITS +: 32];
				acc_q        <= '0;
			end else begin
				acc_q <= sum;
			end
		end
	end

	assign done      = done_q;
	assign depth_sum = res_q[0];
	assign colour    = {res_q[4][15:0], res_q[3][15:0], res_q[2][15:0], res_q[1][15:0]};

endmodule

// ===== hw/rtl/triangle_raster_depth_test.sv =====
// Triangle rasterizer with depth test over a colour/depth pixel store.
// A read is answered from the store's read register via the output registers; vertex
// beats are taken in S_IDLE. The third vertex runs setup (S_BOX, S_MUL, S_CHECK), then
// S_TEST and S_NEXT per box pixel; inside pixels also pass the bit-serial divider,
// the MAC and S_CMP. Reset and the clear command sweep the store to zero, inputs stalled.
// Depends on trd_pkg, trd_store, trd_divider and trd_blend.
`timescale 1ns / 1ps

module triangle_raster_depth_test #(
	parameter int MAX_WIDTH  = trd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = trd_pkg::DEF_MAX_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic signed [15:0] vert_x,
	input  logic signed [15:0] vert_y,
	input  logic signed [31:0] vert_depth,
	input  logic [15:0]        vert_red,
	input  logic [15:0]        vert_green,
	input  logic [15:0]        vert_blue,
	input  logic [15:0]        vert_alpha,
	input  logic [6:0]         pixel_col,
	input  logic [6:0]         pixel_row,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        out_red,
	output logic [15:0]        out_green,
	output logic [15:0]        out_blue,
	output logic [15:0]        out_alpha,
	output logic signed [31:0] out_depth,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import trd_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int C     = COORD_FRAC_BITS;
	localparam int XW    = 16 - C;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_RDRESP = 11'b000_0000_0010,
		S_CLEAR  = 11'b000_0000_0100,
		S_BOX    = 11'b000_0000_1000,
		S_MUL    = 11'b000_0001_0000,
		S_CHECK  = 11'b000_0010_0000,
		S_TEST   = 11'b000_0100_0000,
		S_DIV    = 11'b000_1000_0000,
		S_BLEND  = 11'b001_0000_0000,
		S_CMP    = 11'b010_0000_0000,
		S_NEXT   = 11'b100_0000_0000
	} state_t;

	function automatic logic signed [15:0] min3(input logic signed [15:0] a,
		input logic signed [15:0] b, input logic signed [15:0] c);
		logic signed [15:0] m;
		m    = (a < b) ? a : b;
		min3 = (m < c) ? m : c;
	endfunction

	function automatic logic signed [15:0] max3(input logic signed [15:0] a,
		input logic signed [15:0] b, input logic signed [15:0] c);
		logic signed [15:0] m;
		m    = (a > b) ? a : b;
		max3 = (m > c) ? m : c;
	endfunction

	// edge scaled to one pixel step
	function automatic logic signed [EW-1:0] step(input logic signed [16:0] e);
		step = EW'(e) <<< C;
	endfunction

	state_t              state_q;
	logic [1:0]          vcnt_q;
	logic [7:0]          width_q, height_q, w_eff, h_eff;
	logic                out_valid_q;
	logic [AW-1:0]       clr_q;
	logic [2:0]          mk_q;
	logic                in_acc;

	logic signed [15:0]  hx_q [3];
	logic signed [15:0]  hy_q [3];
	logic [31:0]         hd_q [3];
	logic [COLOUR_W-1:0] hc_q [3];

	logic signed [16:0]  e1x_q, e1y_q, e2x_q, e2y_q;
	logic signed [17:0]  qx0_q, qy0_q;
	logic [7:0]          x_q, y_q, y0_q, x1_q, y1_q;
	logic signed [35:0]  prod_q, hold_q;
	logic signed [EW-1:0] d_q, sn_q, tn_q, snr_q, tnr_q;
	logic signed [EW-1:0] dsx_q, dsy_q, dtx_q, dty_q;
	logic [AW-1:0]       addr_q;
	logic                rdzero_q;
	logic [COLOUR_W-1:0] outcol_q;
	logic [31:0]         outdep_q;

	// setup combinational terms
	logic signed [16:0]  e1x, e1y, e2x, e2y;
	logic signed [15:0]  mnx, mxx, mny, mxy;
	logic [XW-1:0]       x0c, y0c, x1c, y1c;
	logic                box_empty;
	logic signed [17:0]  qx0, qy0, ma, mb;
	logic signed [35:0]  mprod;
	logic                neg, in_tri, rd_in_range, greater;
	logic signed [EW-1:0] st_sum;
	logic [15:0]         pix_lin, rd_lin;
	logic [31:0]         draw;

	logic                mem_en, mem_we;
	logic [AW-1:0]       mem_addr;
	logic [STORE_W-1:0]  mem_wdata, mem_rdata;

	logic                div_start, div_done, blend_start, blend_done;
	logic [QW-1:0]       ws, wt;
	logic [31:0]         blend_depth;
	logic [COLOUR_W-1:0] blend_colour;

	// clamp the frame size registers
	always_comb begin
		if (width_q == 8'd0) begin
			w_eff = 8'd1;
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_eff = 8'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (height_q == 8'd0) begin
			h_eff = 8'd1;
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_eff = 8'(MAX_HEIGHT);
		end else begin
			h_eff = height_q;
		end
	end

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && cmd == CMD_READ);
	assign cfg_ready = 1'b1;

	// bounding box, edges and first pixel offset
	always_comb begin
		e1x = {hx_q[1][15], hx_q[1]} - {hx_q[0][15], hx_q[0]};
		e1y = {hy_q[1][15], hy_q[1]} - {hy_q[0][15], hy_q[0]};
		e2x = {hx_q[2][15], hx_q[2]} - {hx_q[0][15], hx_q[0]};
		e2y = {hy_q[2][15], hy_q[2]} - {hy_q[0][15], hy_q[0]};
		mnx = min3(hx_q[0], hx_q[1], hx_q[2]);
		mxx = max3(hx_q[0], hx_q[1], hx_q[2]);
		mny = min3(hy_q[0], hy_q[1], hy_q[2]);
		mxy = max3(hy_q[0], hy_q[1], hy_q[2]);
		x0c = mnx[15] ? '0 : XW'(mnx[15:C]);
		y0c = mny[15] ? '0 : XW'(mny[15:C]);
		x1c = XW'(mxx[15:C]);
		y1c = XW'(mxy[15:C]);
		if (x1c > XW'(w_eff - 8'd1)) begin
			x1c = XW'(w_eff - 8'd1);
		end
		if (y1c > XW'(h_eff - 8'd1)) begin
			y1c = XW'(h_eff - 8'd1);
		end
		box_empty = mxx[15] || mxy[15] || (x0c > x1c) || (y0c > y1c);
		qx0 = 18'($signed({1'b0, x0c[7:0], {C{1'b0}}})) - 18'(hx_q[0]);
		qy0 = 18'($signed({1'b0, y0c[7:0], {C{1'b0}}})) - 18'(hy_q[0]);
	end

	// operand select for the setup multiplier
	always_comb begin
		case (mk_q)
			3'd0:    begin ma = 18'(e1x_q); mb = 18'(e2y_q); end
			3'd1:    begin ma = 18'(e1y_q); mb = 18'(e2x_q); end
			3'd2:    begin ma = qx0_q;      mb = 18'(e2y_q); end
			3'd3:    begin ma = qy0_q;      mb = 18'(e2x_q); end
			3'd4:    begin ma = 18'(e1x_q); mb = qy0_q;      end
			default: begin ma = 18'(e1y_q); mb = qx0_q;      end
		endcase
		mprod = ma * mb;
	end

	// per-pixel terms
	always_comb begin
		neg         = d_q[EW-1];
		st_sum      = sn_q + tn_q;
		in_tri      = !sn_q[EW-1] && !tn_q[EW-1] && (st_sum <= d_q);
		pix_lin     = {8'd0, y_q} * {8'd0, w_eff} + {8'd0, x_q};
		rd_lin      = {9'd0, pixel_row} * {8'd0, w_eff} + {9'd0, pixel_col};
		rd_in_range = ({1'b0, pixel_col} < w_eff) && ({1'b0, pixel_row} < h_eff);
		draw        = blend_depth ^ DEPTH_BIAS;
		greater     = $signed(draw) > $signed(mem_rdata[STORE_W-1:COLOUR_W]);
	end

	assign div_start   = (state_q == S_TEST) && in_tri;
	assign blend_start = (state_q == S_DIV) && div_done;

	// store port arbitration
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = AW'(pix_lin);
		mem_wdata = {draw, blend_colour};
		unique case (state_q)
			S_IDLE: begin
				mem_en   = in_acc && cmd == CMD_READ && rd_in_range;
				mem_addr = AW'(rd_lin);
			end
			S_CLEAR: begin
				mem_en    = 1'b1;
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			S_TEST: begin
				mem_en = in_tri;
			end
			S_CMP: begin
				mem_en   = greater;
				mem_we   = greater;
				mem_addr = addr_q;
			end
			default: begin
				mem_en = 1'b0;
			end
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			vcnt_q      <= '0;
			mk_q        <= '0;
			width_q     <= SIZE_RESET;
			height_q    <= SIZE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ACTIVE_WIDTH:  width_q  <= cfg_data;
					REG_ACTIVE_HEIGHT: height_q <= cfg_data;
					default:           ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						unique case (cmd)
							CMD_VERTEX: begin
								if (vcnt_q == 2'd2) begin
									vcnt_q  <= '0;
									state_q <= S_BOX;
								end else begin
									vcnt_q <= vcnt_q + 2'd1;
								end
							end
							CMD_READ:  state_q <= S_RDRESP;
							CMD_CLEAR: begin
								clr_q   <= '0;
								state_q <= S_CLEAR;
							end
							default: ;
						endcase
					end
				end
				S_RDRESP: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_BOX: begin
					mk_q    <= '0;
					state_q <= box_empty ? S_IDLE : S_MUL;
				end
				S_MUL: begin
					mk_q <= mk_q + 3'd1;
					if (mk_q == 3'd6) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: state_q <= (d_q == '0) ? S_IDLE : S_TEST;
				S_TEST:  state_q <= in_tri ? S_DIV : S_NEXT;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_BLEND;
					end
				end
				S_BLEND: begin
					if (blend_done) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: state_q <= S_NEXT;
				S_NEXT: begin
					if (y_q == y1_q && x_q == x1_q) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_TEST;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc && cmd == CMD_VERTEX) begin
					hx_q[vcnt_q] <= vert_x;
					hy_q[vcnt_q] <= vert_y;
					hd_q[vcnt_q] <= vert_depth;
					hc_q[vcnt_q] <= {vert_alpha, vert_blue, vert_green, vert_red};
				end
				if (in_acc && cmd == CMD_READ) begin
					rdzero_q <= !rd_in_range;
				end
			end
			S_RDRESP: begin
				outcol_q <= rdzero_q ? '0 : mem_rdata[COLOUR_W-1:0];
				outdep_q <= rdzero_q ? '0 : mem_rdata[STORE_W-1:COLOUR_W];
			end
			S_BOX: begin
				e1x_q <= e1x;
				e1y_q <= e1y;
				e2x_q <= e2x;
				e2y_q <= e2y;
				qx0_q <= qx0;
				qy0_q <= qy0;
				x_q   <= x0c[7:0];
				y_q   <= y0c[7:0];
				y0_q  <= y0c[7:0];
				x1_q  <= x1c[7:0];
				y1_q  <= y1c[7:0];
			end
			S_MUL: begin
				prod_q <= mprod;
				case (mk_q)
					3'd1, 3'd3, 3'd5: hold_q <= prod_q;
					3'd2: d_q  <= EW'(hold_q) - EW'(prod_q);
					3'd4: sn_q <= EW'(hold_q) - EW'(prod_q);
					3'd6: tn_q <= EW'(hold_q) - EW'(prod_q);
					default: ;
				endcase
			end
			S_CHECK: begin
				d_q   <= neg ? -d_q : d_q;
				sn_q  <= neg ? -sn_q : sn_q;
				tn_q  <= neg ? -tn_q : tn_q;
				snr_q <= neg ? -sn_q : sn_q;
				tnr_q <= neg ? -tn_q : tn_q;
				dsx_q <= neg ? -step(e2y_q) : step(e2y_q);
				dsy_q <= neg ? step(e2x_q) : -step(e2x_q);
				dtx_q <= neg ? step(e1y_q) : -step(e1y_q);
				dty_q <= neg ? -step(e1x_q) : step(e1x_q);
			end
			S_TEST: begin
				addr_q <= AW'(pix_lin);
			end
			S_NEXT: begin
				// walk down the column, then move to the next one
				if (y_q != y1_q) begin
					y_q  <= y_q + 8'd1;
					sn_q <= sn_q + dsy_q;
					tn_q <= tn_q + dty_q;
				end else if (x_q != x1_q) begin
					x_q   <= x_q + 8'd1;
					y_q   <= y0_q;
					snr_q <= snr_q + dsx_q;
					tnr_q <= tnr_q + dtx_q;
					sn_q  <= snr_q + dsx_q;
					tn_q  <= tnr_q + dtx_q;
				end
			end
			default: ;
		endcase
	end

	trd_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	trd_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num_a  (sn_q[DVW-1:0]),
		.num_b  (tn_q[DVW-1:0]),
		.den    (d_q[DVW-1:0]),
		.done   (div_done),
		.quo_a  (ws),
		.quo_b  (wt)
	);

	trd_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (blend_start),
		.ws        (ws),
		.wt        (wt),
		.vdepth    (hd_q),
		.vcolour   (hc_q),
		.done      (blend_done),
		.depth_sum (blend_depth),
		.colour    (blend_colour)
	);

	assign out_valid = out_valid_q;
	assign out_red   = outcol_q[15:0];
	assign out_green = outcol_q[31:16];
	assign out_blue  = outcol_q[47:32];
	assign out_alpha = outcol_q[63:48];
	assign out_depth = outdep_q;

endmodule

// ===== hw/rtl/trd_checker.sv =====
// Port-level checks for the triangle raster block, bound to its top level.
// Depends on trd_pkg for the command codes.
`timescale 1ns / 1ps

module trd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  cmd,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] out_red,
	input logic [31:0] out_depth
);
	import trd_pkg::*;

	// a stalled result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_depth) && $stable(out_red))
		else $error("result payload changed while stalled");

	// an accepted read beat is answered by a result beat
	a_read_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_READ |-> ##2 out_valid)
		else $error("read result missing");

	// results only come from reads
	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && cmd == CMD_READ, 2))
		else $error("result without a read");

endmodule

bind triangle_raster_depth_test trd_checker u_trd_checker (.*);

// ===== tb/trd_checker.sv =====
// Scoreboard for triangle_raster_depth_test: mirrors the colour and depth stores,
// rasterizes each completed triangle and checks every read-back beat in order.
// Depends on trd_pkg for the command and register codes.
`timescale 1ns / 1ps

module trd_scoreboard (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic signed [15:0] vert_x,
	input  logic signed [15:0] vert_y,
	input  logic signed [31:0] vert_depth,
	input  logic [15:0]        vert_red,
	input  logic [15:0]        vert_green,
	input  logic [15:0]        vert_blue,
	input  logic [15:0]        vert_alpha,
	input  logic [6:0]         pixel_col,
	input  logic [6:0]         pixel_row,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [15:0]        out_red,
	input  logic [15:0]        out_green,
	input  logic [15:0]        out_blue,
	input  logic [15:0]        out_alpha,
	input  logic signed [31:0] out_depth,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	output int                 fails,
	output int                 pending
);
	import trd_pkg::*;

	localparam int SLOTS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic [15:0] alpha;
		logic [31:0] depth;
	} pixel_t;

	logic [63:0] colour_mem [SLOTS];
	logic [31:0] depth_mem [SLOTS];
	logic [7:0]  width_reg;
	logic [7:0]  height_reg;
	int          vcount;
	longint      held_x [2];
	longint      held_y [2];
	logic [31:0] held_z [2];
	logic [63:0] held_c [2];
	pixel_t      read_q [$];

	function automatic longint frame_size(logic [7:0] v, int maxv);
		if (v == 0) return 1;
		if (int'(v) > maxv) return maxv;
		return longint'(v);
	endfunction

	function automatic logic [63:0] mix(logic [63:0] ws, logic [63:0] wt, logic [63:0] wu,
			logic [63:0] a1, logic [63:0] a2, logic [63:0] a3);
		return (ws * a2 + wt * a3 + wu * a1) >> WEIGHT_BITS;
	endfunction

	function automatic void wipe_stores();
		for (int i = 0; i < SLOTS; i++) begin
			colour_mem[i] = '0;
			depth_mem[i] = '0;
		end
	endfunction

	// Walk the clamped box and depth-test every pixel inside the triangle
	function automatic void draw_triangle(longint px [3], longint py [3],
			logic [31:0] dz [3], logic [63:0] col [3]);
		longint w, h, e1x, e1y, e2x, e2y, d, x0, x1, y0, y1, mnx, mxx, mny, mxy;
		longint qx, qy, sn, tn, addr;
		logic [63:0] b1, b2, b3, ws, wt, wu, dres, c, v;
		logic [31:0] draw;
		bit neg;
		w = frame_size(width_reg, DEF_MAX_WIDTH);
		h = frame_size(height_reg, DEF_MAX_HEIGHT);
		e1x = px[1] - px[0];
		e1y = py[1] - py[0];
		e2x = px[2] - px[0];
		e2y = py[2] - py[0];
		d = e1x * e2y - e1y * e2x;
		if (d == 0) return;
		neg = d < 0;
		if (neg) d = -d;
		mnx = px[0]; mxx = px[0]; mny = py[0]; mxy = py[0];
		for (int k = 1; k < 3; k++) begin
			if (px[k] < mnx) mnx = px[k];
			if (px[k] > mxx) mxx = px[k];
			if (py[k] < mny) mny = py[k];
			if (py[k] > mxy) mxy = py[k];
		end
		if (mxx < 0 || mxy < 0) return;
		x0 = mnx < 0 ? 0 : mnx >>> COORD_FRAC_BITS;
		y0 = mny < 0 ? 0 : mny >>> COORD_FRAC_BITS;
		x1 = mxx >>> COORD_FRAC_BITS;
		y1 = mxy >>> COORD_FRAC_BITS;
		if (x1 > w - 1) x1 = w - 1;
		if (y1 > h - 1) y1 = h - 1;
		// Bias depths so the weighted sum works on unsigned values
		b1 = 64'(dz[0] ^ DEPTH_BIAS);
		b2 = 64'(dz[1] ^ DEPTH_BIAS);
		b3 = 64'(dz[2] ^ DEPTH_BIAS);
		for (longint x = x0; x <= x1; x++) begin
			for (longint y = y0; y <= y1; y++) begin
				qx = (x << COORD_FRAC_BITS) - px[0];
				qy = (y << COORD_FRAC_BITS) - py[0];
				sn = qx * e2y - qy * e2x;
				tn = e1x * qy - e1y * qx;
				if (neg) begin
					sn = -sn;
					tn = -tn;
				end
				if (sn < 0 || tn < 0 || sn + tn > d) continue;
				ws = (64'(sn) << WEIGHT_BITS) / 64'(d);
				wt = (64'(tn) << WEIGHT_BITS) / 64'(d);
				wu = (64'd1 << WEIGHT_BITS) - ws - wt;
				dres = mix(ws, wt, wu, b1, b2, b3);
				draw = dres[31:0] ^ DEPTH_BIAS;
				addr = y * w + x;
				if (addr >= SLOTS) continue;
				if ($signed(draw) <= $signed(depth_mem[addr])) continue;
				c = '0;
				for (int k = 0; k < 4; k++) begin
					v = mix(ws, wt, wu, 64'(col[0][16*k +: 16]), 64'(col[1][16*k +: 16]),
						64'(col[2][16*k +: 16]));
					c[16*k +: 16] = v[15:0];
				end
				colour_mem[addr] = c;
				depth_mem[addr] = draw;
			end
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	initial begin
		fails = 0;
		pending = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		longint px [3], py [3], w, h, addr;
		logic [31:0] dz [3];
		logic [63:0] col [3], vc;
		if (!arst_n) begin
			wipe_stores();
			width_reg = SIZE_RESET;
			height_reg = SIZE_RESET;
			vcount = 0;
			for (int k = 0; k < 2; k++) begin
				held_x[k] = 0;
				held_y[k] = 0;
				held_z[k] = '0;
				held_c[k] = '0;
			end
			read_q.delete();
		end else begin
			// Compare each read-back beat with the oldest expectation
			if (out_valid && !out_stall) begin
				if (read_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected beat, expected none, actual %h %h %h %h %h",
						$time, out_red, out_green, out_blue, out_alpha, out_depth);
				end else begin
					want = read_q.pop_front();
					check_field("red", 32'(want.red), 32'(out_red));
					check_field("green", 32'(want.green), 32'(out_green));
					check_field("blue", 32'(want.blue), 32'(out_blue));
					check_field("alpha", 32'(want.alpha), 32'(out_alpha));
					check_field("depth", want.depth, out_depth);
				end
			end
			// Track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ACTIVE_WIDTH:  width_reg = cfg_data;
					REG_ACTIVE_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			// Advance the model on each accepted command beat
			if (in_valid && !in_stall) begin
				case (cmd)
					CMD_VERTEX: begin
						vc = {vert_alpha, vert_blue, vert_green, vert_red};
						if (vcount < 2) begin
							held_x[vcount] = longint'(vert_x);
							held_y[vcount] = longint'(vert_y);
							held_z[vcount] = vert_depth;
							held_c[vcount] = vc;
							vcount++;
						end else begin
							for (int k = 0; k < 2; k++) begin
								px[k] = held_x[k];
								py[k] = held_y[k];
								dz[k] = held_z[k];
								col[k] = held_c[k];
							end
							px[2] = longint'(vert_x);
							py[2] = longint'(vert_y);
							dz[2] = vert_depth;
							col[2] = vc;
							draw_triangle(px, py, dz, col);
							vcount = 0;
						end
					end
					CMD_READ: begin
						w = frame_size(width_reg, DEF_MAX_WIDTH);
						h = frame_size(height_reg, DEF_MAX_HEIGHT);
						want = '0;
						if (longint'(pixel_col) < w && longint'(pixel_row) < h) begin
							addr = longint'(pixel_row) * w + longint'(pixel_col);
							if (addr < SLOTS)
								want = {colour_mem[addr][15:0], colour_mem[addr][31:16],
									colour_mem[addr][47:32], colour_mem[addr][63:48],
									depth_mem[addr]};
						end
						read_q.push_back(want);
					end
					CMD_CLEAR: wipe_stores();
					default: ;
				endcase
			end
		end
		pending = read_q.size();
	end

endmodule

// ===== tb/triangle_raster_depth_test_test.sv =====
// Top of the triangle_raster_depth_test bench: clock, reset, register writes, command
// traffic with bursty sender and stalling receiver, and the verdict.
// Depends on trd_pkg, triangle_raster_depth_test and trd_scoreboard.
`timescale 1ns / 1ps

module triangle_raster_depth_test_test;
	import trd_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd2;
	localparam int CYCLE_LIMIT = 3_000_000;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] x, y;
		logic [31:0] z;
		logic [15:0] r, g, b, a;
		logic [6:0]  c, w;
	} beat_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
	logic [1:0] cmd, cfg_index;
	logic signed [15:0] vert_x, vert_y;
	logic signed [31:0] vert_depth, out_depth;
	logic [15:0] vert_red, vert_green, vert_blue, vert_alpha;
	logic [15:0] out_red, out_green, out_blue, out_alpha;
	logic [6:0] pixel_col, pixel_row;
	logic [7:0] cfg_data;
	int fails, pending, cycles;
	int burst_left;
	bit want_hold;
	int frame_w, frame_h;

	triangle_raster_depth_test dut (.*);
	trd_scoreboard u_scoreboard (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Give up on a hung run
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: random stall stretches, plus one long hold-off on request
	initial begin
		int hold_cnt, left, mode;
		hold_cnt = 0;
		left = 0;
		mode = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (want_hold) begin
				want_hold = 0;
				hold_cnt = 3000;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 2);
					left = $urandom_range(1, 60);
				end
				left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= 1'($urandom_range(0, 1));
					default: out_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	function automatic beat_t vtx(int x, int y, logic [31:0] z, logic [15:0] r,
			logic [15:0] g, logic [15:0] b, logic [15:0] a);
		beat_t t;
		t.op = CMD_VERTEX;
		t.x = 16'(x); t.y = 16'(y); t.z = z;
		t.r = r; t.g = g; t.b = b; t.a = a;
		t.c = 7'($urandom); t.w = 7'($urandom);
		return t;
	endfunction

	function automatic beat_t other(logic [1:0] op, int col, int row);
		beat_t t;
		t = vtx($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		t.op = op;
		t.c = 7'(col);
		t.w = 7'(row);
		return t;
	endfunction

	// Offer one beat, hold it until taken, then maybe open a gap
	task automatic push(beat_t t);
		int gap;
		cmd <= t.op;
		vert_x <= t.x; vert_y <= t.y; vert_depth <= t.z;
		vert_red <= t.r; vert_green <= t.g; vert_blue <= t.b; vert_alpha <= t.a;
		pixel_col <= t.c; pixel_row <= t.w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 15);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Flush with a read so drawing is finished, then let the block settle
	task automatic settle();
		push(other(CMD_READ, 0, 0));
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(logic [7:0] wv, logic [7:0] hv);
		write_reg(REG_ACTIVE_WIDTH, wv);
		write_reg(REG_ACTIVE_HEIGHT, hv);
		frame_w = (wv == 0) ? 1 : (wv > 128 ? 128 : wv);
		frame_h = (hv == 0) ? 1 : (hv > 128 ? 128 : hv);
	endtask

	// Reads, clears and unused commands among mostly small triangles in the frame, some degenerate or off-frame
	task automatic random_phase(int count);
		int ax, ay, span, kind, tri_pos, pick, vx0, vy0, vx, vy;
		tri_pos = 0;
		ax = 0; ay = 0; span = 16; kind = 0; vx0 = 0; vy0 = 0;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 999);
			if (pick < 5) begin
				push(other(CMD_CLEAR, 0, 0));
			end else if (pick < 15) begin
				push(other(CMD_UNUSED, 0, 0));
			end else if (pick < 330) begin
				if ($urandom_range(0, 9) < 6)
					push(other(CMD_READ, (ax >>> 4) + int'($urandom_range(0, 3)),
						(ay >>> 4) + int'($urandom_range(0, 3))));
				else
					push(other(CMD_READ, $urandom_range(0, 127), $urandom_range(0, 127)));
			end else begin
				if (tri_pos == 0) begin
					ax = int'($urandom_range(0, frame_w * 16 + 32)) - 16;
					ay = int'($urandom_range(0, frame_h * 16 + 32)) - 16;
					span = ($urandom_range(0, 3) == 0) ? 48 : 24;
					kind = $urandom_range(0, 19);
				end
				vx = ax + int'($urandom_range(0, span));
				vy = ay + int'($urandom_range(0, span));
				if (kind == 0 && tri_pos == 2) begin
					vx = vx0;
					vy = vy0;
				end else if (kind == 1) begin
					vx = -int'($urandom_range(1, 32768));
				end
				if (tri_pos == 0) begin
					vx0 = vx;
					vy0 = vy;
				end
				push(vtx(vx, vy, $urandom, $urandom, $urandom, $urandom, $urandom));
				tri_pos = (tri_pos + 1) % 3;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_VERTEX;
		vert_x = '0; vert_y = '0; vert_depth = '0;
		vert_red = '0; vert_green = '0; vert_blue = '0; vert_alpha = '0;
		pixel_col = '0; pixel_row = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ACTIVE_WIDTH;
		cfg_data = '0;
		burst_left = 0;
		want_hold = 0;
		frame_w = 128;
		frame_h = 128;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset contents, both windings, depth test, degenerate, off-frame
		push(other(CMD_READ, 1, 1));
		push(vtx(16, 16, 32'h0001_0000, 16'hFFFF, 16'h0000, 16'h8000, 16'hFFFF));
		push(vtx(80, 16, 32'h0002_0000, 16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF));
		push(vtx(16, 80, 32'h0003_0000, 16'h1234, 16'h5678, 16'hFFFF, 16'h0000));
		push(other(CMD_READ, 2, 2));
		push(vtx(16, 16, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		push(vtx(16, 80, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		push(vtx(80, 16, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		push(other(CMD_READ, 2, 2));
		push(vtx(32, 32, 32'h8000_0000, 16'h0, 16'h0, 16'h0, 16'h0));
		push(vtx(48, 48, 32'h8000_0000, 16'h0, 16'h0, 16'h0, 16'h0));
		push(vtx(64, 64, 32'h8000_0000, 16'h0, 16'h0, 16'h0, 16'h0));
		push(vtx(-32768, -32768, 32'h7FFF_FFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0));
		push(vtx(-32768, 32767, 32'h7FFF_FFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0));
		push(vtx(-16, 32767, 32'h7FFF_FFFF, 16'hFFFF, 16'h0, 16'h0, 16'h0));
		push(other(CMD_UNUSED, 0, 0));
		push(other(CMD_READ, 127, 127));
		push(other(CMD_CLEAR, 0, 0));
		push(other(CMD_READ, 2, 2));
		settle();

		// Directed: tiny frame under a full-range triangle, then out-of-range sizes
		set_frame(8'd1, 8'd1);
		write_reg(REG_UNUSED, 8'hFF);
		push(vtx(-32768, -32768, 32'h0000_0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		push(vtx(32767, -32768, 32'h0000_0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		push(vtx(-32768, 32767, 32'h0000_0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		push(other(CMD_READ, 0, 0));
		push(other(CMD_READ, 1, 0));
		settle();
		set_frame(8'd0, 8'd0);
		push(other(CMD_READ, 0, 0));
		push(other(CMD_READ, 0, 1));
		settle();

		// Random phases over several frame sizes; hold the receiver off in the first
		set_frame(8'd255, 8'd255);
		want_hold = 1;
		random_phase(400);
		settle();
		set_frame(8'd7, 8'd5);
		random_phase(300);
		settle();
		set_frame(8'd1, 8'd128);
		random_phase(250);
		settle();
		set_frame(8'd128, 8'd2);
		random_phase(250);
		settle();
		set_frame(8'd40, 8'd33);
		random_phase(300);
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
